FILE: src/hcs_pkg.sv
package hcs_pkg;

    // histogram geometry
    localparam int COUNT_BITS = 17;
    localparam int NUM_BINS   = 256;
    localparam int PIX_BITS   = 8;
    localparam int BIN_BITS   = $clog2(NUM_BINS);

    // pixel full scale
    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

    // saturation value of one bin
    localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};

    // op codes carried in tuser
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_COUNT   = 2'd1;
    localparam logic [1:0] OP_STRETCH = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_WALK,
        ST_WALK_END,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: src/histogram_contrast_stretch_unit.sv
// Histogram linear contrast stretch for 8-bit grey pixels. Each input word carries an
// op code in s_tuser (clear, count, stretch) and a pixel in s_tdata; only a stretch
// returns a word. Clear drops the per-bin valid flags at once; count reads the bin,
// then does a saturating write of the bin memory. A stretch whose pixel lies strictly
// between the bounds of a non-flat range passes through accept, bound check, eight steps
// of the restoring divider that forms floor((p-low)*255/(high-low)), and the output load;
// any other stretch skips the divider. The first stretch after a clear or count first
// walks all 256 bins of the memory, one read a cycle, to find the lowest and highest
// non-empty bin. The block takes one word at a time and is not ready while it works;
// the output register lets the next word in while a result waits, and a second result
// holds in the output load until the first is taken.
module histogram_contrast_stretch_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel[7:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // pixel_out[7:0], range_low[15:8], range_high[23:16]
);
    import hcs_pkg::*;

    // bin memory and per-bin valid flags
    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   bin_valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    // sequencer and datapath registers
    state_t                state_reg, state_next;
    logic [PIX_BITS-1:0]   pix_reg, pix_next;
    logic [PIX_BITS-1:0]   low_bound_reg, low_bound_next;
    logic [PIX_BITS-1:0]   high_bound_reg, high_bound_next;
    logic                  stale_reg, stale_next;
    logic                  found_reg, found_next;
    logic [BIN_BITS-1:0]   walk_idx_reg, walk_idx_next;
    logic                  chk_en_reg, chk_en_next;
    logic [BIN_BITS-1:0]   chk_idx_reg, chk_idx_next;
    logic                  chk_vbit_reg, chk_vbit_next;
    logic [PIX_BITS-1:0]   rem_reg, rem_next;
    logic [PIX_BITS-1:0]   shift_reg, shift_next;
    logic [PIX_BITS-1:0]   div_reg, div_next;
    logic [2:0]            step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [23:0]           out_data_reg, out_data_next;

    // memory control
    logic                  rd_en;
    logic [BIN_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  clear_all;

    // combinational helpers
    logic                  accept;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  nonempty;
    logic [PIX_BITS-1:0]   diff;
    logic [PIX_BITS-1:0]   span;
    logic [15:0]           numer;
    logic [PIX_BITS:0]     trial;
    logic                  fits;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // bin read data, zero where the bin was never written since the last clear
    assign cur_count = chk_vbit_reg ? rd_data_reg : '0;
    assign nonempty  = chk_vbit_reg && (rd_data_reg != '0);

    // divider setup and the shared compare/subtract step
    assign diff  = pix_reg - low_bound_reg;
    assign span  = high_bound_reg - low_bound_reg;
    assign numer = {diff, 8'd0} - {8'd0, diff};
    assign trial = {rem_reg, shift_reg[PIX_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg  <= PIX_MAX;
            high_bound_reg <= '0;
            stale_reg      <= 1'b1;
            found_reg      <= 1'b0;
            walk_idx_reg   <= '0;
            chk_en_reg     <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
            stale_reg      <= stale_next;
            found_reg      <= found_next;
            walk_idx_reg   <= walk_idx_next;
            chk_en_reg     <= chk_en_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        chk_idx_reg  <= chk_idx_next;
        chk_vbit_reg <= chk_vbit_next;
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        div_reg      <= div_next;
        out_data_reg <= out_data_next;
    end

    // bin memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    // valid flags: clear drops them all, a write sets its bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
        end
        else if (clear_all)
        begin
            bin_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            bin_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        pix_next        = pix_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        stale_next      = stale_reg;
        found_next      = found_reg;
        walk_idx_next   = walk_idx_reg;
        chk_en_next     = 1'b0;
        chk_idx_next    = chk_idx_reg;
        chk_vbit_next   = chk_vbit_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = walk_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = pix_reg;
        wr_data         = cur_count + COUNT_BITS'(1);
        clear_all       = 1'b0;

        // bound tracking while walk reads come back
        if (chk_en_reg && nonempty)
        begin
            if (!found_reg)
            begin
                low_bound_next = chk_idx_reg;
                found_next     = 1'b1;
            end
            high_bound_next = chk_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pix_next = s_tdata;
                    unique case (s_tuser)
                        OP_CLEAR:
                        begin
                            clear_all  = 1'b1;
                            stale_next = 1'b1;
                        end
                        OP_COUNT:
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = s_tdata;
                            chk_vbit_next = bin_valid_reg[s_tdata];
                            state_next    = ST_CNT_WR;
                        end
                        OP_STRETCH:
                        begin
                            if (stale_reg)
                            begin
                                low_bound_next  = PIX_MAX;
                                high_bound_next = '0;
                                found_next      = 1'b0;
                                walk_idx_next   = '0;
                                state_next      = ST_WALK;
                            end
                            else
                            begin
                                state_next = ST_PREP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CNT_WR:
            begin
                // saturating increment
                if (cur_count != BIN_MAX)
                begin
                    wr_en = 1'b1;
                end
                stale_next = 1'b1;
                state_next = ST_IDLE;
            end

            ST_WALK:
            begin
                rd_en         = 1'b1;
                chk_en_next   = 1'b1;
                chk_idx_next  = walk_idx_reg;
                chk_vbit_next = bin_valid_reg[walk_idx_reg];
                walk_idx_next = walk_idx_reg + BIN_BITS'(1);
                if (walk_idx_reg == BIN_BITS'(NUM_BINS - 1))
                begin
                    state_next = ST_WALK_END;
                end
            end

            ST_WALK_END:
            begin
                stale_next = 1'b0;
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                if ((high_bound_reg <= low_bound_reg) || (pix_reg <= low_bound_reg))
                begin
                    shift_next = '0;
                    state_next = ST_DONE;
                end
                else if (pix_reg >= high_bound_reg)
                begin
                    shift_next = PIX_MAX;
                    state_next = ST_DONE;
                end
                else
                begin
                    // quotient fits 8 bits since p-low < high-low
                    rem_next   = numer[15:8];
                    shift_next = numer[7:0];
                    div_next   = span;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // one restoring step, quotient bits shift in from the bottom
                if (fits)
                begin
                    rem_next = PIX_BITS'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = trial[PIX_BITS-1:0];
                end
                shift_next = {shift_reg[PIX_BITS-2:0], fits};
                step_next  = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {high_bound_reg, low_bound_reg, shift_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // bounds are either ordered or the empty-histogram pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |->
            (low_bound_reg <= high_bound_reg) ||
            ((low_bound_reg == PIX_MAX) && (high_bound_reg == '0)))
        else $error("bounds out of order after walk");

    // divider partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // a flat or empty range always maps to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[23:16] <= m_tdata[15:8])) |-> (m_tdata[7:0] == '0))
        else $error("nonzero output for flat range");

    // the output word only changes when it is taken or empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result lost while output stalled");

endmodule
